// File: sv/crsd_pkg.sv
// package for the column rle sprite decoder
// holds limits, register indexes, phase and emitter state types, control structs
// no dependencies
package crsd_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam logic [9:0] MAX_W = 10'(MAX_WIDTH);
  localparam logic [9:0] MAX_H = 10'(MAX_HEIGHT);

  localparam logic [2:0] CFG_DRAW_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_DRAW_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_SKIP_COLUMNS = 3'd2;
  localparam logic [2:0] CFG_SKIP_ROWS    = 3'd3;
  localparam logic [2:0] CFG_COLOR_FORMAT = 3'd4;

  localparam logic [7:0] EMPTY_COLUMN = 8'hff;
  localparam logic [7:0] REPEAT_BASE  = 8'hdf;
  localparam logic [7:0] BLEND_BASE   = 8'he8;
  localparam logic [8:0] LONG_RUN     = 9'd256;

  typedef enum logic [7:0] {
    PH_MODE   = 8'b0000_0001,
    PH_TOTAL  = 8'b0000_0010,
    PH_RUNLEN = 8'b0000_0100,
    PH_GAP    = 8'b0000_1000,
    PH_LIT    = 8'b0001_0000,
    PH_PK     = 8'b0010_0000,
    PH_PKVAL  = 8'b0100_0000,
    PH_SKIP   = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    ES_IDLE = 2'b01,
    ES_EMIT = 2'b10
  } emit_state_t;

  typedef struct packed {
    logic   load;
    phase_t op;
    logic   end_col;
    logic   emit;
    logic   step;
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic is_empty;
    logic col_lt_skip;
    logic b_zero;
    logic b_rep;
    logic total_zero;
    logic skip_last;
    logic run_last;
    logic packed_mode;
    logic em_multi;
    logic pend_last;
    logic out_free;
  } status_t;

endpackage

// File: sv/crsd_ctrl.sv
// controller for the column rle sprite decoder: parse phase and pixel burst state
// drives the datapath through crsd_pkg::cmd_t and reads crsd_pkg::status_t
// depends on crsd_pkg
module crsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_frame_start,
  input  crsd_pkg::status_t st,
  output logic              in_ready,
  output crsd_pkg::cmd_t    cmd
);

  crsd_pkg::phase_t      phase_r, phase_nxt, op;
  crsd_pkg::emit_state_t es_r, es_nxt;
  logic load, end_col, emit, step, seg_end;

  assign op       = in_frame_start ? crsd_pkg::PH_MODE : phase_r;
  assign in_ready = (es_r == crsd_pkg::ES_IDLE) && st.out_free;
  assign load     = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    es_nxt    = es_r;
    end_col   = 1'b0;
    emit      = 1'b0;
    step      = 1'b0;
    seg_end   = 1'b0;
    if (load) begin
      phase_nxt = op;
      unique case (op)
        crsd_pkg::PH_MODE: begin
          if (!st.at_limit) begin
            if (st.is_empty) begin
              end_col   = 1'b1;
              phase_nxt = crsd_pkg::PH_MODE;
            end else begin
              phase_nxt = crsd_pkg::PH_TOTAL;
            end
          end
        end
        crsd_pkg::PH_TOTAL: begin
          if (st.col_lt_skip) begin
            if (st.b_zero) begin
              end_col   = 1'b1;
              phase_nxt = crsd_pkg::PH_MODE;
            end else begin
              phase_nxt = crsd_pkg::PH_SKIP;
            end
          end else begin
            phase_nxt = crsd_pkg::PH_RUNLEN;
          end
        end
        crsd_pkg::PH_SKIP: begin
          if (st.skip_last) begin
            end_col   = 1'b1;
            phase_nxt = crsd_pkg::PH_MODE;
          end
        end
        crsd_pkg::PH_RUNLEN: phase_nxt = crsd_pkg::PH_GAP;
        crsd_pkg::PH_GAP: begin
          phase_nxt = st.packed_mode ? crsd_pkg::PH_PK : crsd_pkg::PH_LIT;
        end
        crsd_pkg::PH_LIT: begin
          emit    = 1'b1;
          seg_end = st.run_last;
        end
        crsd_pkg::PH_PK: begin
          if (st.b_rep) begin
            phase_nxt = crsd_pkg::PH_PKVAL;
          end else begin
            emit    = 1'b1;
            seg_end = st.run_last;
          end
        end
        crsd_pkg::PH_PKVAL: begin
          emit = 1'b1;
          if (st.run_last) begin
            seg_end = 1'b1;
          end else begin
            phase_nxt = crsd_pkg::PH_PK;
          end
        end
        default: phase_nxt = crsd_pkg::PH_MODE;
      endcase
      if (seg_end) begin
        if (st.total_zero) begin
          end_col   = 1'b1;
          phase_nxt = crsd_pkg::PH_MODE;
        end else begin
          phase_nxt = crsd_pkg::PH_RUNLEN;
        end
      end
      if (emit && st.em_multi) begin
        es_nxt = crsd_pkg::ES_EMIT;
      end
    end
    if (es_r == crsd_pkg::ES_EMIT && st.out_free) begin
      step = 1'b1;
      if (st.pend_last) begin
        es_nxt = crsd_pkg::ES_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crsd_pkg::PH_MODE;
      es_r    <= crsd_pkg::ES_IDLE;
    end else begin
      phase_r <= phase_nxt;
      es_r    <= es_nxt;
    end
  end

  assign cmd.load    = load;
  assign cmd.op      = op;
  assign cmd.end_col = end_col;
  assign cmd.emit    = emit;
  assign cmd.step    = step;

  a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    es_r == crsd_pkg::ES_EMIT |-> !in_ready)
    else $error("input word accepted during pixel burst");

  a_emit_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (cmd.op == crsd_pkg::PH_LIT || cmd.op == crsd_pkg::PH_PK ||
                  cmd.op == crsd_pkg::PH_PKVAL))
    else $error("pixel emitted outside a data phase");

  a_end_col_to_mode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_col |=> phase_r == crsd_pkg::PH_MODE)
    else $error("column end did not return to mode byte");

endmodule

// File: sv/crsd_dpath.sv
// datapath for the column rle sprite decoder: config registers, column and row
// counters, run bookkeeping and the pixel output register
// depends on crsd_pkg; controlled by crsd_ctrl
module crsd_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [9:0]        cfg_data,
  input  logic [7:0]        in_stream_byte,
  input  logic              in_frame_start,
  input  crsd_pkg::cmd_t    cmd,
  output crsd_pkg::status_t st,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [8:0]        out_pixel_column,
  output logic [8:0]        out_pixel_row,
  output logic [7:0]        out_pixel_value,
  output logic              out_blend,
  output logic              out_last
);

  logic [9:0] draw_width_r, draw_height_r;
  logic [8:0] skip_columns_r, skip_rows_r;
  logic       color_format_r;

  logic       packed_r, packed_nxt;
  logic [9:0] column_count_r, column_count_nxt;
  logic [7:0] total_r, total_nxt;
  logic [8:0] run_r, run_nxt;
  logic [9:0] row_r, row_nxt;
  logic [8:0] rts_r, rts_nxt;
  logic [5:0] repeat_r, repeat_nxt;
  logic [5:0] pend_r, pend_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [8:0] col_out_r, col_out_nxt, row_out_r, row_out_nxt;
  logic [7:0] val_out_r, val_out_nxt;
  logic       blend_out_r, blend_out_nxt, last_out_r, last_out_nxt;

  logic [7:0]  b;
  logic [9:0]  eff_w, eff_h, col_eff, avail;
  logic [10:0] col_limit, row_gap;
  logic [8:0]  run_len, sub, em_cnt_w, rts_em;
  logic [5:0]  em_cnt, rem, rem_eff;
  logic        em_over, blend, load_px;
  logic [7:0]  val;

  assign b         = in_stream_byte;
  assign eff_w     = (draw_width_r > crsd_pkg::MAX_W) ? crsd_pkg::MAX_W : draw_width_r;
  assign eff_h     = (draw_height_r > crsd_pkg::MAX_H) ? crsd_pkg::MAX_H : draw_height_r;
  assign col_eff   = in_frame_start ? 10'd0 : column_count_r;
  assign col_limit = 11'(skip_columns_r) + 11'(eff_w);

  assign run_len = (b == 8'd0) ? crsd_pkg::LONG_RUN : 9'(b);
  assign sub     = (packed_r ? 9'(b) : run_len) + 9'd2;
  assign row_gap = 11'(row_r) + 11'(b) - 11'(rts_r);

  assign em_cnt   = (cmd.op == crsd_pkg::PH_PKVAL) ? repeat_r : 6'd1;
  assign em_cnt_w = 9'(em_cnt);
  assign em_over  = em_cnt_w > rts_r;
  assign rem      = em_over ? 6'(em_cnt_w - rts_r) : 6'd0;
  assign rts_em   = em_over ? 9'd0 : rts_r - em_cnt_w;
  assign avail    = (row_r < eff_h) ? eff_h - row_r : 10'd0;
  assign rem_eff  = (10'(rem) < avail) ? rem : 6'(avail);
  assign load_px  = cmd.load && cmd.emit && (rem_eff != 6'd0);

  assign blend = color_format_r && (b >= crsd_pkg::BLEND_BASE);
  assign val   = blend ? b - crsd_pkg::BLEND_BASE : b;

  assign st.at_limit    = 11'(col_eff) >= col_limit;
  assign st.is_empty    = b == crsd_pkg::EMPTY_COLUMN;
  assign st.col_lt_skip = col_eff < 10'(skip_columns_r);
  assign st.b_zero      = b == 8'd0;
  assign st.b_rep       = b > crsd_pkg::REPEAT_BASE;
  assign st.total_zero  = total_r == 8'd0;
  assign st.skip_last   = total_r <= 8'd1;
  assign st.run_last    = run_r <= 9'd1;
  assign st.packed_mode = packed_r;
  assign st.em_multi    = rem_eff > 6'd1;
  assign st.pend_last   = pend_r == 6'd1;
  assign st.out_free    = !out_valid_r || out_ready;

  always_comb begin
    packed_nxt       = packed_r;
    column_count_nxt = column_count_r;
    total_nxt        = total_r;
    run_nxt          = run_r;
    row_nxt          = row_r;
    rts_nxt          = rts_r;
    repeat_nxt       = repeat_r;
    pend_nxt         = pend_r;
    if (cmd.load) begin
      column_count_nxt = col_eff + 10'(cmd.end_col);
      unique case (cmd.op)
        crsd_pkg::PH_MODE: begin
          if (!st.at_limit && !st.is_empty) begin
            packed_nxt = b[7];
            if (!st.col_lt_skip) begin
              row_nxt = 10'd0;
              rts_nxt = skip_rows_r;
            end
          end
        end
        crsd_pkg::PH_TOTAL: total_nxt = b;
        crsd_pkg::PH_SKIP: begin
          if (total_r != 8'd0) begin
            total_nxt = total_r - 8'd1;
          end
        end
        crsd_pkg::PH_RUNLEN: begin
          run_nxt   = run_len;
          total_nxt = (9'(total_r) > sub) ? total_r - sub[7:0] : 8'd0;
        end
        crsd_pkg::PH_GAP: begin
          if (9'(b) <= rts_r) begin
            rts_nxt = rts_r - 9'(b);
          end else begin
            rts_nxt = 9'd0;
            row_nxt = (row_gap > 11'(eff_h)) ? eff_h : row_gap[9:0];
          end
        end
        crsd_pkg::PH_LIT, crsd_pkg::PH_PKVAL: begin
          rts_nxt = rts_em;
          if (run_r != 9'd0) begin
            run_nxt = run_r - 9'd1;
          end
        end
        crsd_pkg::PH_PK: begin
          if (run_r != 9'd0) begin
            run_nxt = run_r - 9'd1;
          end
          if (st.b_rep) begin
            repeat_nxt = 6'(b - crsd_pkg::REPEAT_BASE);
          end else begin
            rts_nxt = rts_em;
          end
        end
        default: ;
      endcase
    end
    out_valid_nxt = out_valid_r;
    col_out_nxt   = col_out_r;
    row_out_nxt   = row_out_r;
    val_out_nxt   = val_out_r;
    blend_out_nxt = blend_out_r;
    last_out_nxt  = last_out_r;
    if (load_px) begin
      out_valid_nxt = 1'b1;
      col_out_nxt   = 9'(col_eff - 10'(skip_columns_r));
      row_out_nxt   = row_r[8:0];
      val_out_nxt   = val;
      blend_out_nxt = blend;
      last_out_nxt  = rem_eff == 6'd1;
      row_nxt       = row_r + 10'd1;
      pend_nxt      = rem_eff - 6'd1;
    end else if (cmd.step) begin
      out_valid_nxt = 1'b1;
      row_out_nxt   = row_r[8:0];
      last_out_nxt  = pend_r == 6'd1;
      row_nxt       = row_r + 10'd1;
      pend_nxt      = pend_r - 6'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_width_r   <= 10'd0;
      draw_height_r  <= 10'd0;
      skip_columns_r <= 9'd0;
      skip_rows_r    <= 9'd0;
      color_format_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        crsd_pkg::CFG_DRAW_WIDTH:   draw_width_r   <= cfg_data;
        crsd_pkg::CFG_DRAW_HEIGHT:  draw_height_r  <= cfg_data;
        crsd_pkg::CFG_SKIP_COLUMNS: skip_columns_r <= cfg_data[8:0];
        crsd_pkg::CFG_SKIP_ROWS:    skip_rows_r    <= cfg_data[8:0];
        crsd_pkg::CFG_COLOR_FORMAT: color_format_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packed_r       <= 1'b0;
      column_count_r <= 10'd0;
      total_r        <= 8'd0;
      run_r          <= 9'd0;
      row_r          <= 10'd0;
      rts_r          <= 9'd0;
      repeat_r       <= 6'd0;
      pend_r         <= 6'd0;
      out_valid_r    <= 1'b0;
    end else begin
      packed_r       <= packed_nxt;
      column_count_r <= column_count_nxt;
      total_r        <= total_nxt;
      run_r          <= run_nxt;
      row_r          <= row_nxt;
      rts_r          <= rts_nxt;
      repeat_r       <= repeat_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_out_r   <= col_out_nxt;
    row_out_r   <= row_out_nxt;
    val_out_r   <= val_out_nxt;
    blend_out_r <= blend_out_nxt;
    last_out_r  <= last_out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_column = col_out_r;
  assign out_pixel_row    = row_out_r;
  assign out_pixel_value  = val_out_r;
  assign out_blend        = blend_out_r;
  assign out_last         = last_out_r;

  a_pixel_within_height: assert property (@(posedge clk) disable iff (!rst_n)
    load_px |-> row_r < eff_h)
    else $error("pixel written past height limit");

  a_step_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> pend_r != 6'd0)
    else $error("burst step with no pending pixel");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r <= crsd_pkg::LONG_RUN)
    else $error("run byte count out of range");

endmodule

// File: sv/column_rle_sprite_decoder.sv
// Column run-length sprite decoder. Takes one stream word per cycle on in_* and
// writes pixels (column, row, value, blend flag) on out_*, with out_last marking the
// final pixel of each input word. The value word after a repeat code in packed data
// yields up to 32 pixels at one per cycle while out_ready is high, set by the single
// output register and the burst counter, and holds in_ready low until the burst
// drains. Output back-pressure stalls input.
// Configuration goes through cfg_* (index 0 draw_width, 1 draw_height, 2 skip_columns,
// 3 skip_rows, 4 color_format) and is always ready; there is no clearing pass after
// reset.
// Depends on crsd_pkg, crsd_ctrl and crsd_dpath.
module column_rle_sprite_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] out_pixel_column,
  output logic [8:0] out_pixel_row,
  output logic [7:0] out_pixel_value,
  output logic       out_blend,
  output logic       out_last
);

  crsd_pkg::cmd_t    cmd;
  crsd_pkg::status_t st;

  assign cfg_ready = 1'b1;

  crsd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_frame_start (in_frame_start),
    .st             (st),
    .in_ready       (in_ready),
    .cmd            (cmd)
  );

  crsd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_stream_byte   (in_stream_byte),
    .in_frame_start   (in_frame_start),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_value  (out_pixel_value),
    .out_blend        (out_blend),
    .out_last         (out_last)
  );

endmodule

// File: test/column_rle_sprite_decoder_tb.sv
// testbench for column_rle_sprite_decoder: feeds directed and random sprite streams,
// predicts every pixel write and checks each one as it leaves the block
// depends on crsd_pkg and column_rle_sprite_decoder
`timescale 1ns / 100ps

module column_rle_sprite_decoder_tb;

  localparam int          RAND_WORDS    = 150;
  localparam int          CUT_WORDS     = 24;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          LIMIT_NS      = 2_000_000;
  localparam logic [2:0]  CFG_UNUSED    = 3'd5;

  typedef struct packed {
    logic [8:0] column;
    logic [8:0] row;
    logic [7:0] value;
    logic       blend;
    logic       is_last;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_first;
  } stream_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_stream_byte = '0;
  logic       in_frame_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [8:0] out_pixel_column;
  logic [8:0] out_pixel_row;
  logic [7:0] out_pixel_value;
  logic       out_blend;
  logic       out_last;

  column_rle_sprite_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_value  (out_pixel_value),
    .out_blend        (out_blend),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  // decoder mirror: registers and parse state
  logic [9:0]        draw_w = '0;
  logic [9:0]        draw_h = '0;
  logic [8:0]        skip_cols = '0;
  logic [8:0]        skip_rows = '0;
  logic              fmt = 1'b0;
  crsd_pkg::phase_t  ph = crsd_pkg::PH_MODE;
  logic              packed_data = 1'b0;
  logic [9:0]        col_cnt = '0;
  logic [9:0]        total_left = '0;
  logic [8:0]        run_left = '0;
  logic [9:0]        row_pos = '0;
  logic [8:0]        rows_skip_left = '0;
  logic [5:0]        rep_cnt = '0;

  pixel_t       pixel_q[$];
  stream_word_t word_q[$];
  logic         frame_mark = 1'b0;
  logic         in_taken = 1'b0;
  logic         idle_on = 1'b1;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           stim_words = 0;
  int           words_taken = 0;
  int           pixels_checked = 0;
  int           settings_done = 0;
  int           errors = 0;

  function automatic int height_cap();
    return (draw_h > crsd_pkg::MAX_H) ? int'(crsd_pkg::MAX_H) : int'(draw_h);
  endfunction

  function automatic string pixel_text(input pixel_t px);
    return $sformatf("col %0d row %0d value 0x%02h blend %0b last %0b",
                     px.column, px.row, px.value, px.blend, px.is_last);
  endfunction

  task automatic put_pixels(input logic [7:0] v, input int count);
    pixel_t px;
    logic   mark;
    int     i;
    mark = fmt && (v >= crsd_pkg::BLEND_BASE);
    for (i = 0; i < count; i++) begin
      if (rows_skip_left != 0) begin
        rows_skip_left = rows_skip_left - 9'd1;
      end else if (int'(row_pos) < height_cap()) begin
        px.column  = 9'(col_cnt - 10'(skip_cols));
        px.row     = row_pos[8:0];
        px.value   = mark ? v - crsd_pkg::BLEND_BASE : v;
        px.blend   = mark;
        px.is_last = 1'b0;
        pixel_q.push_back(px);
        row_pos = row_pos + 10'd1;
      end
    end
  endtask

  task automatic close_column();
    col_cnt = col_cnt + 10'd1;
    ph = crsd_pkg::PH_MODE;
  endtask

  task automatic close_segment();
    if (total_left == 0) close_column();
    else ph = crsd_pkg::PH_RUNLEN;
  endtask

  task automatic decode_word(input logic [7:0] b, input logic frame_first);
    int     run, sub, nrow, lim_w, queued;
    pixel_t px;
    queued = pixel_q.size();
    lim_w = (draw_w > crsd_pkg::MAX_W) ? int'(crsd_pkg::MAX_W) : int'(draw_w);
    if (frame_first) begin
      col_cnt = '0;
      ph = crsd_pkg::PH_MODE;
    end
    case (ph)
      crsd_pkg::PH_MODE: begin
        if (int'(col_cnt) < int'(skip_cols) + lim_w) begin
          if (b == crsd_pkg::EMPTY_COLUMN) begin
            close_column();
          end else begin
            packed_data = b[7];
            ph = crsd_pkg::PH_TOTAL;
            if (col_cnt >= 10'(skip_cols)) begin
              row_pos = '0;
              rows_skip_left = skip_rows;
            end
          end
        end
      end
      crsd_pkg::PH_TOTAL: begin
        total_left = 10'(b);
        if (col_cnt < 10'(skip_cols)) begin
          if (b == 0) close_column();
          else ph = crsd_pkg::PH_SKIP;
        end else begin
          ph = crsd_pkg::PH_RUNLEN;
        end
      end
      crsd_pkg::PH_SKIP: begin
        if (total_left != 0) total_left = total_left - 10'd1;
        if (total_left == 0) close_column();
      end
      crsd_pkg::PH_RUNLEN: begin
        run = (b == 0) ? int'(crsd_pkg::LONG_RUN) : int'(b);
        sub = (packed_data ? int'(b) : run) + 2;
        run_left = 9'(run);
        total_left = (int'(total_left) > sub) ? 10'(int'(total_left) - sub) : '0;
        ph = crsd_pkg::PH_GAP;
      end
      crsd_pkg::PH_GAP: begin
        if (int'(b) <= int'(rows_skip_left)) begin
          rows_skip_left = rows_skip_left - 9'(b);
        end else begin
          nrow = int'(row_pos) + int'(b) - int'(rows_skip_left);
          rows_skip_left = '0;
          row_pos = 10'((nrow > height_cap()) ? height_cap() : nrow);
        end
        ph = packed_data ? crsd_pkg::PH_PK : crsd_pkg::PH_LIT;
      end
      crsd_pkg::PH_LIT: begin
        put_pixels(b, 1);
        if (run_left != 0) run_left = run_left - 9'd1;
        if (run_left == 0) close_segment();
      end
      crsd_pkg::PH_PK: begin
        if (run_left != 0) run_left = run_left - 9'd1;
        if (b > crsd_pkg::REPEAT_BASE) begin
          rep_cnt = 6'(b - crsd_pkg::REPEAT_BASE);
          ph = crsd_pkg::PH_PKVAL;
        end else begin
          put_pixels(b, 1);
          if (run_left == 0) close_segment();
        end
      end
      crsd_pkg::PH_PKVAL: begin
        put_pixels(b, int'(rep_cnt));
        if (run_left != 0) run_left = run_left - 9'd1;
        if (run_left == 0) close_segment();
        else ph = crsd_pkg::PH_PK;
      end
      default: ;
    endcase
    if (pixel_q.size() > queued) begin
      px = pixel_q.pop_back();
      px.is_last = 1'b1;
      pixel_q.push_back(px);
    end
  endtask

  // output check first, then prediction for the word taken at this edge
  always @(posedge clk) begin : check_pixels
    pixel_t got, want;
    in_taken <= in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      got = '{column: out_pixel_column, row: out_pixel_row, value: out_pixel_value,
              blend: out_blend, is_last: out_last};
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel write %s", $time, pixel_text(got));
      end else begin
        want = pixel_q.pop_front();
        pixels_checked++;
        if (got.column !== want.column || got.row !== want.row || got.value !== want.value ||
            got.blend !== want.blend || got.is_last !== want.is_last) begin
          errors++;
          $display("%0t: expected %s, got %s", $time, pixel_text(want), pixel_text(got));
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      words_taken++;
      decode_word(in_stream_byte, in_frame_start);
    end
  end

  always @(negedge clk) begin : feed_words
    stream_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (word_q.size() != 0 && !(idle_on && $urandom_range(99) < 28)) begin
        w = word_q.pop_front();
        in_valid <= 1'b1;
        in_stream_byte <= w.data;
        in_frame_start <= w.frame_first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drain_pixels
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 28);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      crsd_pkg::CFG_DRAW_WIDTH:   draw_w = val;
      crsd_pkg::CFG_DRAW_HEIGHT:  draw_h = val;
      crsd_pkg::CFG_SKIP_COLUMNS: skip_cols = val[8:0];
      crsd_pkg::CFG_SKIP_ROWS:    skip_rows = val[8:0];
      crsd_pkg::CFG_COLOR_FORMAT: fmt = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(input logic [9:0] w, input logic [9:0] h,
                                input logic [8:0] sc, input logic [8:0] sr, input logic f);
    write_reg(crsd_pkg::CFG_DRAW_WIDTH, w);
    write_reg(crsd_pkg::CFG_DRAW_HEIGHT, h);
    write_reg(crsd_pkg::CFG_SKIP_COLUMNS, 10'(sc));
    write_reg(crsd_pkg::CFG_SKIP_ROWS, 10'(sr));
    write_reg(crsd_pkg::CFG_COLOR_FORMAT, 10'(f));
    settings_done++;
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid || pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_word(input logic [7:0] b);
    stream_word_t w;
    w.data = b;
    w.frame_first = frame_mark;
    word_q.push_back(w);
    frame_mark = 1'b0;
    stim_words++;
  endtask

  task automatic add_column(input logic pk, input int nseg, input logic zero_run);
    int runs[$];
    int total, left, r, i;
    total = 0;
    for (i = 0; i < nseg; i++) begin
      r = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
      if (zero_run && i == nseg - 1) r = int'(crsd_pkg::LONG_RUN);
      runs.push_back(r);
      total += (pk && r == int'(crsd_pkg::LONG_RUN)) ? 2 : r + 2;
    end
    if (total > 255) total = 255;
    if ($urandom_range(15) == 0) total = $urandom_range(255);
    add_word(pk ? 8'($urandom_range(8'h80, 8'hfe)) : 8'($urandom_range(8'h7f)));
    add_word(8'(total));
    for (i = 0; i < runs.size(); i++) begin
      add_word(8'(runs[i]));
      add_word(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
      // long run cut short, the next frame start ends it
      left = (zero_run && i == nseg - 1) ? CUT_WORDS : runs[i];
      while (left > 0) begin
        if (pk && $urandom_range(2) == 0) begin
          add_word(8'($urandom_range(8'he0, 8'hff)));
          add_word(8'($urandom));
          left -= 2;
        end else begin
          add_word(pk ? 8'($urandom_range(crsd_pkg::REPEAT_BASE)) : 8'($urandom));
          left--;
        end
      end
    end
  endtask

  initial begin : main
    int         p, c;
    logic [9:0] w, h;
    logic [8:0] sc, sr;
    logic       f;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_settings(10'd3, crsd_pkg::MAX_H, 9'd0, 9'd0, 1'b1);
    frame_mark = 1'b1;
    add_word(crsd_pkg::EMPTY_COLUMN);
    add_word(8'h00); add_word(8'd6); add_word(8'd4); add_word(8'd0);
    add_word(8'h00); add_word(8'hff); add_word(crsd_pkg::BLEND_BASE); add_word(8'he7);
    add_word(8'hfe); add_word(8'd9); add_word(8'd4); add_word(8'd2);
    add_word(8'he0); add_word(8'h11); add_word(8'hff); add_word(8'he9);
    add_word(8'd1); add_word(8'd1); add_word(8'hf0); add_word(8'h55);
    add_word(8'h12);
    frame_mark = 1'b1;
    add_word(8'h7f); add_word(8'h20); add_word(8'h00); add_word(8'h05); add_word(8'h3c);
    frame_mark = 1'b1;
    add_word(crsd_pkg::EMPTY_COLUMN);
    wait_idle();

    stim_words = 0;
    p = 0;
    while (stim_words < RAND_WORDS || p < 5) begin
      case (p)
        0: begin w = 10'd1023; h = 10'd1023; sc = 9'd2; sr = 9'd3; f = 1'b0; end
        1: begin w = crsd_pkg::MAX_W; h = 10'd6; sc = 9'd0; sr = 9'd0; f = 1'b1; end
        2: begin w = 10'd0; h = crsd_pkg::MAX_H; sc = 9'd511; sr = 9'd511; f = 1'b0; end
        3: begin w = 10'd1; h = 10'd1; sc = 9'd1; sr = 9'd0; f = 1'b1; end
        default: begin
          w = 10'($urandom_range(1, 6));
          h = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(4, 300));
          sc = 9'($urandom_range(2));
          sr = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(5));
          f = 1'($urandom_range(1));
        end
      endcase
      write_settings(w, h, sc, sr, f);
      if (p == 2) write_reg(CFG_UNUSED + 3'($urandom_range(2)), 10'($urandom));
      idle_on = (p != 1);
      if (p == 0) begin
        frame_mark = 1'b1;
        add_word(crsd_pkg::EMPTY_COLUMN);
        add_word(crsd_pkg::EMPTY_COLUMN);
        add_column(1'b1, 1, 1'b1);
        hold_req = hold_req + 1;
      end
      do begin
        frame_mark = 1'b1;
        for (c = $urandom_range(1, 3); c > 0; c--) begin
          if ($urandom_range(6) == 0) add_word(crsd_pkg::EMPTY_COLUMN);
          else add_column(1'($urandom_range(1)), $urandom_range(1, 3), 1'b0);
        end
        if ($urandom_range(3) == 0) begin
          for (c = $urandom_range(3, 8); c > 0; c--) begin
            frame_mark = ($urandom_range(9) == 0);
            add_word(8'($urandom));
          end
        end
      end while (stim_words < (p + 1) * RAND_WORDS / 5);
      wait_idle();
      p++;
    end

    $display("covered literal and packed columns, long runs, skipped columns and rows,");
    $display("%0d words in, %0d pixel writes checked, %0d register settings",
             words_taken, pixels_checked, settings_done);
    if (errors == 0) begin
      $display("column_rle_sprite_decoder_tb OK");
    end else begin
      $display("%0d pixel write errors", errors);
      $display("column_rle_sprite_decoder_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("%0t: timeout with %0d pixel writes outstanding", $time, pixel_q.size());
    $display("column_rle_sprite_decoder_tb NOT OK");
    $finish;
  end

endmodule

// File: column_rle_sprite_decoder.f
sv/crsd_pkg.sv
sv/crsd_ctrl.sv
sv/crsd_dpath.sv
sv/column_rle_sprite_decoder.sv
test/column_rle_sprite_decoder_tb.sv
